@@ hdl/tcc_pkg.sv @@
// Shared types, constants and helper functions for the text console cursor engine.
// Used by the interfaces, the register block, the shared adder and the top level.
// Has no dependencies of its own.
package tcc_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 128;

	// The shared unit is wide enough for any column or row limit in range.
	localparam int UNIT_W = 9;

	localparam int CFG_W    = 8;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 1;
	localparam int CHAR_W   = 8;
	localparam int ACTION_W = 2;
	localparam int FIELD_W  = 7;
	localparam int COUNT_W  = 5;
	localparam int TAB_BITS = 3;

	localparam logic [CFG_W-1:0] COLUMNS_RESET = 8'd64;
	localparam logic [CFG_W-1:0] ROWS_RESET    = 8'd48;
	localparam int               MIN_COLUMNS   = 8;
	localparam int               MIN_ROWS      = 1;

	// Register indexes, taken from paddr[2].
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_FIRST = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7E;

	localparam logic [FIELD_W-1:0] GLYPH_MISSING = 7'd95;
	localparam logic [FIELD_W-1:0] GLYPH_SPACE   = 7'd0;
	localparam logic [COUNT_W-1:0] RESULT_CAP    = 5'd15;

	typedef enum logic [ACTION_W-1:0] {
		ACT_DRAW   = 2'd0,
		ACT_SCROLL = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUT   = 1'b0,
		FUNC_CLEAR = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,
		S_NL,
		S_DRAW,
		S_BS,
		S_OUT
	} state_t;

	// Effective screen geometry after clamping.
	typedef struct packed {
		logic [UNIT_W-1:0] cols;
		logic [UNIT_W-1:0] rows;
		logic [UNIT_W-1:0] last_row;
	} tcc_cfg_t;

	typedef struct packed {
		logic [UNIT_W-1:0] a;
		logic [UNIT_W-1:0] b;
		logic [UNIT_W-1:0] lim;
	} alu_req_t;

	typedef struct packed {
		logic [UNIT_W-1:0] sum;
		logic              ge;
	} alu_rsp_t;

	function automatic logic [FIELD_W-1:0] glyph_of(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] d;
		d = ch - CH_FIRST;
		if (ch < CH_FIRST || ch > CH_LAST) begin
			return GLYPH_MISSING;
		end
		return d[FIELD_W-1:0];
	endfunction

endpackage

@@ hdl/tcc_in_if.sv @@
// Input channel of the text console cursor engine: one byte or clear request per transfer.
// Depends on tcc_pkg for field widths.
interface tcc_in_if;
	logic                        valid;
	logic                        ready;
	logic [tcc_pkg::FUNC_W-1:0]  func;
	logic [tcc_pkg::CHAR_W-1:0]  char_code;

	modport source(output valid, func, char_code, input ready);
	modport sink(input valid, func, char_code, output ready);
endinterface

@@ hdl/tcc_out_if.sv @@
// Output channel of the text console cursor engine: one painter command per transfer.
// Depends on tcc_pkg for field widths.
interface tcc_out_if;
	logic                          valid;
	logic                          ready;
	logic [tcc_pkg::ACTION_W-1:0]  action;
	logic [tcc_pkg::FIELD_W-1:0]   column;
	logic [tcc_pkg::FIELD_W-1:0]   row;
	logic [tcc_pkg::FIELD_W-1:0]   glyph;
	logic                          last;

	modport source(output valid, action, column, row, glyph, last, input ready);
	modport sink(input valid, action, column, row, glyph, last, output ready);
endinterface

@@ hdl/tcc_regs.sv @@
// Configuration registers (columns, rows) behind an APB-style port, and their clamping
// to the effective screen geometry. Depends on tcc_pkg.
module tcc_regs #(
	parameter int MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tcc_pkg::MAX_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcc_pkg::ADDR_W-1:0]   paddr,
	input  logic [tcc_pkg::DATA_W-1:0]   pwdata,
	output logic [tcc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output tcc_pkg::tcc_cfg_t            cfg
);

	localparam logic [tcc_pkg::UNIT_W-1:0] MaxC = tcc_pkg::UNIT_W'(MAX_COLUMNS);
	localparam logic [tcc_pkg::UNIT_W-1:0] MinC = tcc_pkg::UNIT_W'(tcc_pkg::MIN_COLUMNS);
	localparam logic [tcc_pkg::UNIT_W-1:0] MaxR = tcc_pkg::UNIT_W'(MAX_ROWS);
	localparam logic [tcc_pkg::UNIT_W-1:0] MinR = tcc_pkg::UNIT_W'(tcc_pkg::MIN_ROWS);

	logic [tcc_pkg::CFG_W-1:0]  columns_q;
	logic [tcc_pkg::CFG_W-1:0]  rows_q;
	logic                       index;
	logic                       wr_en;
	logic [tcc_pkg::UNIT_W-1:0] cols_ext;
	logic [tcc_pkg::UNIT_W-1:0] rows_ext;
	logic [tcc_pkg::UNIT_W-1:0] rows_eff;

	// Registers sit on 32-bit words, so the low address bits are ignored.
	assign index  = paddr[2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= tcc_pkg::COLUMNS_RESET;
			rows_q    <= tcc_pkg::ROWS_RESET;
		end else if (wr_en) begin
			if (index == tcc_pkg::REG_ROWS) begin
				rows_q <= pwdata[tcc_pkg::CFG_W-1:0];
			end else begin
				columns_q <= pwdata[tcc_pkg::CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (index == tcc_pkg::REG_ROWS) begin
			prdata = tcc_pkg::DATA_W'(rows_q);
		end else begin
			prdata = tcc_pkg::DATA_W'(columns_q);
		end
	end

	assign cols_ext = tcc_pkg::UNIT_W'(columns_q);
	assign rows_ext = tcc_pkg::UNIT_W'(rows_q);

	always_comb begin
		priority if (cols_ext < MinC) begin
			cfg.cols = MinC;
		end else if (cols_ext > MaxC) begin
			cfg.cols = MaxC;
		end else begin
			cfg.cols = cols_ext;
		end
		priority if (rows_ext < MinR) begin
			rows_eff = MinR;
		end else if (rows_ext > MaxR) begin
			rows_eff = MaxR;
		end else begin
			rows_eff = rows_ext;
		end
		cfg.rows     = rows_eff;
		cfg.last_row = rows_eff - tcc_pkg::UNIT_W'(1);
	end

endmodule

@@ hdl/tcc_alu.sv @@
// Shared add-and-compare unit of the cursor engine: sum = a + b, ge = (sum >= lim).
// Every cursor step (wrap test, row advance, column advance, backspace) goes through it.
// Depends on tcc_pkg.
module tcc_alu (
	input  tcc_pkg::alu_req_t req,
	output tcc_pkg::alu_rsp_t rsp
);

	logic [tcc_pkg::UNIT_W-1:0] sum;

	assign sum     = req.a + req.b;
	assign rsp.sum = sum;
	assign rsp.ge  = (sum >= req.lim);

endmodule

@@ hdl/text_console_cursor.sv @@
// Text console cursor engine: top level with the sequencer, cursor state and output register.
// Depends on tcc_pkg, tcc_in_if, tcc_out_if, tcc_regs and tcc_alu.
//
// The block takes one console byte (or a clear request) per input transfer and answers with
// zero or more painter commands, the final one flagged by last. Items are handled one at a
// time: a single add-and-compare unit, stepped by a small sequencer, does the wrap test, the
// row advance and the column advance one after another, and the input is ready only while
// the sequencer is idle. A printable byte passes the wrap test, then the row advance if it
// wraps to a new line, with a scroll first if that line also scrolls, then the column advance.
// A tab gives up to fifteen results. A result that waits on the output holds the sequencer.
module text_console_cursor #(
	parameter int MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tcc_pkg::MAX_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tcc_pkg::DATA_W-1:0]  pwdata,
	output logic [tcc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	tcc_in_if.sink                      in_ch,
	tcc_out_if.source                   out_ch
);

	// The column counter wraps at 256 like the byte-wide cursor it models.
	localparam int CW = ($clog2(MAX_COLUMNS + 1) > 8) ? 8 : $clog2(MAX_COLUMNS + 1);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	tcc_pkg::tcc_cfg_t cfg;
	tcc_pkg::alu_req_t alu_req;
	tcc_pkg::alu_rsp_t alu_rsp;

	tcc_pkg::state_t st_q;
	tcc_pkg::state_t st_d;
	tcc_pkg::state_t resume_q;

	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [tcc_pkg::COUNT_W-1:0] n_q;
	logic                        is_tab_q;
	logic                        is_nl_q;
	logic [tcc_pkg::CHAR_W-1:0]  ch_q;

	tcc_pkg::action_t             act_q;
	logic [tcc_pkg::FIELD_W-1:0]  ocol_q;
	logic [tcc_pkg::FIELD_W-1:0]  orow_q;
	logic [tcc_pkg::FIELD_W-1:0]  oglyph_q;
	logic                         olast_q;

	logic in_fire;
	logic out_fire;
	logic scroll;
	logic tab_more;
	logic is_clear;

	tcc_regs #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	tcc_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign is_clear = (in_ch.func == tcc_pkg::FUNC_CLEAR);
	assign scroll   = alu_rsp.ge;

	// A tab keeps drawing spaces until the column is a multiple of eight or the
	// result count reaches its cap.
	assign tab_more = is_tab_q
		&& (alu_rsp.sum[tcc_pkg::TAB_BITS-1:0] != '0)
		&& ((n_q + tcc_pkg::COUNT_W'(1)) < tcc_pkg::RESULT_CAP);

	// Outputs of the sequencer: handshake and operands of the shared unit.
	always_comb begin
		in_ch.ready  = (st_q == tcc_pkg::S_IDLE);
		out_ch.valid = (st_q == tcc_pkg::S_OUT);
		alu_req.a    = tcc_pkg::UNIT_W'(col_q);
		alu_req.b    = '0;
		alu_req.lim  = cfg.cols;
		unique case (st_q)
			tcc_pkg::S_NL: begin
				alu_req.a   = tcc_pkg::UNIT_W'(row_q);
				alu_req.b   = tcc_pkg::UNIT_W'(1);
				alu_req.lim = cfg.rows;
			end
			tcc_pkg::S_DRAW: begin
				alu_req.b = tcc_pkg::UNIT_W'(1);
			end
			tcc_pkg::S_BS: begin
				alu_req.b = '1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			tcc_pkg::S_IDLE: begin
				if (in_fire) begin
					priority if (is_clear) begin
						st_d = tcc_pkg::S_OUT;
					end else if (in_ch.char_code == tcc_pkg::CH_NL) begin
						st_d = tcc_pkg::S_NL;
					end else if (in_ch.char_code == tcc_pkg::CH_CR) begin
						st_d = tcc_pkg::S_IDLE;
					end else if (in_ch.char_code == tcc_pkg::CH_BS) begin
						st_d = tcc_pkg::S_BS;
					end else begin
						st_d = tcc_pkg::S_WRAP;
					end
				end
			end
			tcc_pkg::S_WRAP: begin
				st_d = alu_rsp.ge ? tcc_pkg::S_NL : tcc_pkg::S_DRAW;
			end
			tcc_pkg::S_NL: begin
				priority if (scroll) begin
					st_d = tcc_pkg::S_OUT;
				end else if (is_nl_q) begin
					st_d = tcc_pkg::S_IDLE;
				end else begin
					st_d = tcc_pkg::S_DRAW;
				end
			end
			tcc_pkg::S_DRAW: begin
				st_d = tcc_pkg::S_OUT;
			end
			tcc_pkg::S_BS: begin
				st_d = tcc_pkg::S_IDLE;
			end
			tcc_pkg::S_OUT: begin
				if (out_fire) begin
					st_d = olast_q ? tcc_pkg::S_IDLE : resume_q;
				end
			end
			default: begin
				st_d = tcc_pkg::S_IDLE;
			end
		endcase
	end

	// Control state and cursor position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= tcc_pkg::S_IDLE;
			resume_q <= tcc_pkg::S_IDLE;
			col_q    <= '0;
			row_q    <= '0;
			n_q      <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				tcc_pkg::S_IDLE: begin
					if (in_fire) begin
						n_q <= '0;
						if (is_clear) begin
							col_q <= '0;
							row_q <= '0;
						end else if (in_ch.char_code == tcc_pkg::CH_CR) begin
							col_q <= '0;
						end
					end
				end
				tcc_pkg::S_NL: begin
					col_q <= '0;
					if (scroll) begin
						row_q    <= cfg.last_row[RW-1:0];
						n_q      <= n_q + tcc_pkg::COUNT_W'(1);
						resume_q <= tcc_pkg::S_DRAW;
					end else begin
						row_q <= alu_rsp.sum[RW-1:0];
					end
				end
				tcc_pkg::S_DRAW: begin
					col_q    <= alu_rsp.sum[CW-1:0];
					n_q      <= n_q + tcc_pkg::COUNT_W'(1);
					resume_q <= tcc_pkg::S_WRAP;
				end
				tcc_pkg::S_BS: begin
					if (col_q != '0) begin
						col_q <= alu_rsp.sum[CW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item details and the output register.
	always_ff @(posedge clk) begin
		unique case (st_q)
			tcc_pkg::S_IDLE: begin
				if (in_fire) begin
					ch_q     <= in_ch.char_code;
					is_tab_q <= (in_ch.char_code == tcc_pkg::CH_TAB);
					is_nl_q  <= (in_ch.char_code == tcc_pkg::CH_NL);
					act_q    <= tcc_pkg::ACT_CLEAR;
					ocol_q   <= '0;
					orow_q   <= '0;
					oglyph_q <= '0;
					olast_q  <= 1'b1;
				end
			end
			tcc_pkg::S_NL: begin
				act_q    <= tcc_pkg::ACT_SCROLL;
				ocol_q   <= '0;
				orow_q   <= '0;
				oglyph_q <= '0;
				olast_q  <= is_nl_q;
			end
			tcc_pkg::S_DRAW: begin
				act_q    <= tcc_pkg::ACT_DRAW;
				ocol_q   <= tcc_pkg::FIELD_W'(col_q);
				orow_q   <= tcc_pkg::FIELD_W'(row_q);
				oglyph_q <= is_tab_q ? tcc_pkg::GLYPH_SPACE : tcc_pkg::glyph_of(ch_q);
				olast_q  <= !tab_more;
			end
			default: begin
			end
		endcase
	end

	assign out_ch.action = act_q;
	assign out_ch.column = ocol_q;
	assign out_ch.row    = orow_q;
	assign out_ch.glyph  = oglyph_q;
	assign out_ch.last   = olast_q;

endmodule

@@ hdl/tcc_checker.sv @@
// Port-level checks for the text console cursor engine, bound to the top level.
// Depends on tcc_pkg and on the ports of text_console_cursor.
module tcc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tcc_pkg::ACTION_W-1:0]  action,
	input logic [tcc_pkg::FIELD_W-1:0]   column,
	input logic [tcc_pkg::FIELD_W-1:0]   row,
	input logic [tcc_pkg::FIELD_W-1:0]   glyph,
	input logic                          last
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(column)
			&& $stable(row) && $stable(glyph) && $stable(last))
		else $error("stalled result changed");

	// One item at a time: no new byte is taken while a result is pending.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// A clear is always the only result of its item and carries no cell.
	a_clear_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tcc_pkg::ACT_CLEAR |->
			last && column == '0 && row == '0 && glyph == '0)
		else $error("malformed clear command");

	// A scroll carries no cell and no glyph.
	a_scroll_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tcc_pkg::ACT_SCROLL |->
			column == '0 && row == '0 && glyph == '0)
		else $error("malformed scroll command");

	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tcc_pkg::ACT_DRAW |-> glyph <= tcc_pkg::GLYPH_MISSING)
		else $error("glyph index out of range");

endmodule

bind text_console_cursor tcc_checker u_tcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.action   (out_ch.action),
	.column   (out_ch.column),
	.row      (out_ch.row),
	.glyph    (out_ch.glyph),
	.last     (out_ch.last)
);

@@ test/text_console_cursor_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text console cursor engine.
// It predicts the painter commands for each console byte, checks every transfer against them,
// and exercises the screen geometry registers. Needs tcc_pkg, tcc_in_if, tcc_out_if and the top.
module text_console_cursor_test;

	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 55;
	localparam int PRESSURE_ITEMS = 40;
	localparam int NUM_PHASES    = 9;
	localparam int TAB_CAP       = 15;

	typedef struct packed {
		tcc_pkg::action_t            action;
		logic [tcc_pkg::FIELD_W-1:0] column;
		logic [tcc_pkg::FIELD_W-1:0] row;
		logic [tcc_pkg::FIELD_W-1:0] glyph;
		logic                        last;
	} command_t;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_ITEM_TYPED,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic                       f;
		logic [tcc_pkg::CHAR_W-1:0] ch;
		logic                       reg_sel;
		logic [tcc_pkg::CFG_W-1:0]  value;
		command_t                   typed;
	} stim_row_t;

	localparam command_t NONE = '0;

	localparam stim_row_t SCRIPT [31] = '{
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_CLEAR, 8'hFF, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_CLEAR, 7'd0, 7'd0, 7'd0, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, 8'h41, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd0, 7'd0, 7'd33, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, 8'h20, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd1, 7'd0, 7'd0, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, 8'h7E, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd2, 7'd0, 7'd94, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, 8'h7F, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd3, 7'd0, 7'd95, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, 8'h00, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd4, 7'd0, 7'd95, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, 8'hFF, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd5, 7'd0, 7'd95, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, 8'h1F, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd6, 7'd0, 7'd95, 1'b1}},
		'{ROW_ITEM_TYPED, tcc_pkg::FUNC_PUT, tcc_pkg::CH_TAB, tcc_pkg::REG_COLUMNS, 8'd0,
			'{tcc_pkg::ACT_DRAW, 7'd7, 7'd0, 7'd0, 1'b1}},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_BS, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_CR, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_BS, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_NL, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_TAB, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, 8'h0B, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		// Narrowest screen with the cursor left beyond both edges.
		'{ROW_WRITE, tcc_pkg::FUNC_PUT, 8'h00, tcc_pkg::REG_COLUMNS, 8'd8, NONE},
		'{ROW_WRITE, tcc_pkg::FUNC_PUT, 8'h00, tcc_pkg::REG_ROWS, 8'd1, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, 8'h5A, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_TAB, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_TAB, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_NL, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		// An odd width lets the second tab wrap, scroll and run into the result cap.
		'{ROW_WRITE, tcc_pkg::FUNC_PUT, 8'h00, tcc_pkg::REG_COLUMNS, 8'd15, NONE},
		'{ROW_WRITE, tcc_pkg::FUNC_PUT, 8'h00, tcc_pkg::REG_ROWS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_TAB, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_TAB, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, 8'h61, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_WRITE, tcc_pkg::FUNC_PUT, 8'h00, tcc_pkg::REG_COLUMNS, 8'd255, NONE},
		'{ROW_WRITE, tcc_pkg::FUNC_PUT, 8'h00, tcc_pkg::REG_ROWS, 8'd255, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_CLEAR, tcc_pkg::CH_NL, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, 8'h80, tcc_pkg::REG_COLUMNS, 8'd0, NONE},
		'{ROW_ITEM, tcc_pkg::FUNC_PUT, tcc_pkg::CH_BS, tcc_pkg::REG_COLUMNS, 8'd0, NONE}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tcc_pkg::ADDR_W-1:0] paddr;
	logic [tcc_pkg::DATA_W-1:0] pwdata;
	logic [tcc_pkg::DATA_W-1:0] prdata;
	logic pready;

	tcc_in_if  in_ch();
	tcc_out_if out_ch();

	text_console_cursor uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	always #4 clk = ~clk;

	// Predicted screen state and geometry registers.
	logic [tcc_pkg::CFG_W-1:0] cfg_columns = tcc_pkg::COLUMNS_RESET;
	logic [tcc_pkg::CFG_W-1:0] cfg_rows    = tcc_pkg::ROWS_RESET;
	logic [7:0]                cur_col     = '0;
	logic [7:0]                cur_row     = '0;

	command_t step_cmds[$];
	command_t pending_cmds[$];

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	function automatic int unsigned screen_cols();
		int unsigned c;
		c = 32'(cfg_columns);
		if (c < tcc_pkg::MIN_COLUMNS) c = tcc_pkg::MIN_COLUMNS;
		if (c > tcc_pkg::MAX_COLUMNS_DEF) c = tcc_pkg::MAX_COLUMNS_DEF;
		return c;
	endfunction

	function automatic int unsigned screen_rows();
		int unsigned r;
		r = 32'(cfg_rows);
		if (r < tcc_pkg::MIN_ROWS) r = tcc_pkg::MIN_ROWS;
		if (r > tcc_pkg::MAX_ROWS_DEF) r = tcc_pkg::MAX_ROWS_DEF;
		return r;
	endfunction

	function automatic void emit_cmd(input tcc_pkg::action_t a, input logic [7:0] col,
			input logic [7:0] row, input logic [tcc_pkg::FIELD_W-1:0] glyph);
		command_t cmd;
		cmd.action = a;
		cmd.column = col[tcc_pkg::FIELD_W-1:0];
		cmd.row    = row[tcc_pkg::FIELD_W-1:0];
		cmd.glyph  = glyph;
		cmd.last   = 1'b0;
		step_cmds.push_back(cmd);
	endfunction

	function automatic void line_feed();
		int unsigned r;
		r = screen_rows();
		cur_col = '0;
		cur_row = cur_row + 8'd1;
		if (cur_row == 8'd0 || cur_row >= r) begin
			emit_cmd(tcc_pkg::ACT_SCROLL, 8'd0, 8'd0, 7'd0);
			cur_row = 8'(r - 1);
		end
	endfunction

	function automatic void draw_char(input logic [tcc_pkg::CHAR_W-1:0] ch);
		logic [tcc_pkg::CHAR_W-1:0] idx;
		if (cur_col >= screen_cols()) line_feed();
		idx = ch - tcc_pkg::CH_FIRST;
		if (ch < tcc_pkg::CH_FIRST || ch > tcc_pkg::CH_LAST) begin
			emit_cmd(tcc_pkg::ACT_DRAW, cur_col, cur_row, tcc_pkg::GLYPH_MISSING);
		end else begin
			emit_cmd(tcc_pkg::ACT_DRAW, cur_col, cur_row, idx[tcc_pkg::FIELD_W-1:0]);
		end
		cur_col = cur_col + 8'd1;
	endfunction

	// Works out the commands one console byte or clear request produces.
	function automatic void console_step(input tcc_pkg::func_t f,
			input logic [tcc_pkg::CHAR_W-1:0] ch);
		command_t tail;
		step_cmds.delete();
		if (f == tcc_pkg::FUNC_CLEAR) begin
			cur_col = '0;
			cur_row = '0;
			emit_cmd(tcc_pkg::ACT_CLEAR, 8'd0, 8'd0, 7'd0);
		end else begin
			unique case (ch)
				tcc_pkg::CH_NL: line_feed();
				tcc_pkg::CH_CR: cur_col = '0;
				tcc_pkg::CH_TAB: begin
					do begin
						draw_char(tcc_pkg::CH_FIRST);
					end while (cur_col[tcc_pkg::TAB_BITS-1:0] != '0
						&& step_cmds.size() < TAB_CAP);
				end
				tcc_pkg::CH_BS: if (cur_col > 8'd0) cur_col = cur_col - 8'd1;
				default: draw_char(ch);
			endcase
		end
		if (step_cmds.size() > 0) begin
			tail = step_cmds.pop_back();
			tail.last = 1'b1;
			step_cmds.push_back(tail);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic f, input logic [tcc_pkg::CHAR_W-1:0] ch,
			input logic use_typed, input command_t typed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.func      <= f;
		in_ch.char_code <= ch;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		console_step(tcc_pkg::func_t'(f), ch);
		if (use_typed) begin
			pending_cmds.push_back(typed);
		end else begin
			foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
		end
		@(negedge clk);
	endtask

	task automatic send_random();
		int unsigned pick;
		logic [tcc_pkg::CHAR_W-1:0] ch;
		logic f;
		pick = $urandom_range(99);
		ch = tcc_pkg::CHAR_W'($urandom_range(255));
		f = tcc_pkg::FUNC_PUT;
		if (pick < 5) f = tcc_pkg::FUNC_CLEAR;
		else if (pick < 15) ch = tcc_pkg::CH_NL;
		else if (pick < 20) ch = tcc_pkg::CH_CR;
		else if (pick < 30) ch = tcc_pkg::CH_TAB;
		else if (pick < 36) ch = tcc_pkg::CH_BS;
		else if (pick < 85) begin
			ch = tcc_pkg::CHAR_W'($urandom_range(tcc_pkg::CH_LAST, tcc_pkg::CH_FIRST));
		end
		send_item(f, ch, 1'b0, NONE);
	endtask

	// Drops valid and waits until the block has nothing left to say.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_cmds.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [tcc_pkg::CFG_W-1:0] value);
		paddr   <= {sel, 2'b00};
		pwdata  <= {24'($urandom()), value};
		pwrite  <= 1'b1;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == tcc_pkg::REG_COLUMNS) cfg_columns = value;
		else cfg_rows = value;
		@(negedge clk);
		if (prdata !== tcc_pkg::DATA_W'(value)) begin
			$display("%0t: register read back expected %0d, got %0d", $time, value, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: random back-pressure, plus a long hold-off when one is requested.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : command_check
		command_t got;
		command_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.action = tcc_pkg::action_t'(out_ch.action);
			got.column = out_ch.column;
			got.row    = out_ch.row;
			got.glyph  = out_ch.glyph;
			got.last   = out_ch.last;
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command act %0d col %0d row %0d glyph %0d last %0d",
					$time, got.action, got.column, got.row, got.glyph, got.last);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				if (got !== want) begin
					$display({"%0t: expected act %0d col %0d row %0d glyph %0d last %0d,",
						" got act %0d col %0d row %0d glyph %0d last %0d"},
						$time, want.action, want.column, want.row, want.glyph, want.last,
						got.action, got.column, got.row, got.glyph, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n_items;
		logic [tcc_pkg::CFG_W-1:0] cols_val;
		logic [tcc_pkg::CFG_W-1:0] rows_val;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.func      <= tcc_pkg::FUNC_PUT;
		in_ch.char_code <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct  = 20;
		recv_stall_pct = 20;
		foreach (SCRIPT[i]) begin
			unique case (SCRIPT[i].kind)
				ROW_WRITE: begin
					settle();
					write_reg(SCRIPT[i].reg_sel, SCRIPT[i].value);
				end
				ROW_ITEM_TYPED: send_item(SCRIPT[i].f, SCRIPT[i].ch, 1'b1, SCRIPT[i].typed);
				default: send_item(SCRIPT[i].f, SCRIPT[i].ch, 1'b0, NONE);
			endcase
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			unique case (phase)
				0: begin cols_val = 8'd0;   rows_val = 8'd0;   end
				1: begin cols_val = 8'd128; rows_val = 8'd128; end
				2: begin cols_val = 8'd8;   rows_val = 8'd1;   end
				3: begin cols_val = 8'd255; rows_val = 8'd255; end
				4: begin cols_val = 8'd13;  rows_val = 8'd3;   end
				5: begin
					cols_val = tcc_pkg::CFG_W'($urandom_range(128, 8));
					rows_val = tcc_pkg::CFG_W'($urandom_range(128, 1));
				end
				6: begin
					cols_val = tcc_pkg::CFG_W'($urandom_range(255));
					rows_val = tcc_pkg::CFG_W'($urandom_range(255));
				end
				7: begin
					cols_val = tcc_pkg::COLUMNS_RESET;
					rows_val = tcc_pkg::ROWS_RESET;
				end
				default: begin cols_val = 8'd9; rows_val = 8'd2; end
			endcase
			write_reg(tcc_pkg::REG_COLUMNS, cols_val);
			write_reg(tcc_pkg::REG_ROWS, rows_val);
			send_idle_pct  = (phase % 4 == 1) ? 61 : (phase % 4 == 3) ? 20 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 61 : (phase % 4 == 3) ? 20 : 0;
			n_items = PHASE_ITEMS;
			if (phase == NUM_PHASES - 1) begin
				// The receiver blocks for a long while so the input side backs up.
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				n_items = PRESSURE_ITEMS;
				@(posedge clk);
				hold_left = LONG_HOLD;
				@(negedge clk);
			end
			repeat (n_items) send_random();
		end

		in_ch.valid <= 1'b0;
		while (pending_cmds.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
